/* rtl/core/tet_pkg.sv */
package tet_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 64;
  localparam int TIME_W  = 32;
  localparam int EXP_W   = TIME_W + 1;
  localparam int COUNT_W = 6;

  // Reported count saturates at the output width
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int SAT_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(1);

  // Command codes (code 3 behaves as count only)
  localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RENEW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;    // capture transaction, clear scan trackers
    logic scan;    // issue a table read and advance the address
    logic commit;  // write back and publish the result
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;  // read address is at the last slot
  } ctl_status_t;

endpackage

/* rtl/core/tet_ctrl.sv */
module tet_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tet_pkg::ctl_status_t status,
  output tet_pkg::ctl_cmd_t    cmd
);

  tet_pkg::state_t state;
  tet_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      tet_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = tet_pkg::ST_SCAN;
        end
      end
      tet_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = tet_pkg::ST_DRAIN;
        end
      end
      // last read result is evaluated here
      tet_pkg::ST_DRAIN: begin
        state_next = tet_pkg::ST_WRITE;
      end
      tet_pkg::ST_WRITE: begin
        cmd.commit = 1'b1;
        state_next = tet_pkg::ST_IDLE;
      end
      default: begin
        state_next = tet_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a scan");

  a_commit_ends_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !busy)
    else $error("controller stayed busy after commit");

endmodule

/* rtl/core/tet_datapath.sv */
module tet_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tet_pkg::ctl_cmd_t            cmd,
  output tet_pkg::ctl_status_t         status,
  input  logic [tet_pkg::CMD_W-1:0]    command,
  input  logic [tet_pkg::KEY_W-1:0]    lease_key,
  input  logic [tet_pkg::TIME_W-1:0]   current_time,
  input  logic                         cfg_we,
  input  logic [tet_pkg::TIME_W-1:0]   cfg_data,
  output logic                         done,
  output logic [tet_pkg::COUNT_W-1:0]  live_count,
  output logic                         applied,
  output logic                         table_full
);

  // Table storage
  logic                        slot_valid [tet_pkg::TABLE_DEPTH];
  logic [tet_pkg::KEY_W-1:0]   mem_key    [tet_pkg::TABLE_DEPTH];
  logic [tet_pkg::EXP_W-1:0]   mem_exp    [tet_pkg::TABLE_DEPTH];

  logic [tet_pkg::TIME_W-1:0]  lifetime;

  // Captured transaction
  logic [tet_pkg::CMD_W-1:0]   cmd_q;
  logic [tet_pkg::KEY_W-1:0]   key_q;
  logic [tet_pkg::TIME_W-1:0]  now_q;

  // Read stage
  logic [tet_pkg::IDX_W-1:0]   addr;
  logic                        rd_en;
  logic [tet_pkg::IDX_W-1:0]   rd_idx;
  logic                        rd_vld;
  logic [tet_pkg::KEY_W-1:0]   rd_key;
  logic [tet_pkg::EXP_W-1:0]   rd_exp;

  // Scan trackers
  logic                        match_found;
  logic [tet_pkg::IDX_W-1:0]   match_idx;
  logic                        match_live;
  logic                        free_found;
  logic [tet_pkg::IDX_W-1:0]   free_idx;
  logic [tet_pkg::CNT_W-1:0]   live_cnt;

  logic                        e_live;
  logic                        e_match;

  logic                        do_write;
  logic                        old_live;
  logic                        new_live;
  logic                        no_slot;
  logic [tet_pkg::IDX_W-1:0]   tgt;
  logic [tet_pkg::EXP_W-1:0]   new_exp;
  logic [tet_pkg::CNT_W-1:0]   count_after;
  logic [tet_pkg::SAT_W-1:0]   count_wide;
  logic [tet_pkg::COUNT_W-1:0] count_sat;

  assign status.scan_last = (addr == tet_pkg::IDX_W'(tet_pkg::TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= tet_pkg::LIFETIME_RESET;
    end else if (cfg_we) begin
      lifetime <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      key_q <= lease_key;
      now_q <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr  <= '0;
      rd_en <= 1'b0;
    end else begin
      rd_en <= cmd.scan;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.scan && !status.scan_last) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
    rd_vld <= slot_valid[addr];
    rd_key <= mem_key[addr];
    rd_exp <= mem_exp[addr];
  end

  assign e_live  = rd_vld && (rd_exp > {1'b0, now_q});
  assign e_match = rd_vld && (rd_key == key_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found <= 1'b0;
      match_live  <= 1'b0;
      free_found  <= 1'b0;
      live_cnt    <= '0;
    end else if (rd_en) begin
      if (e_match && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
        match_live  <= e_live;
      end
      if (!e_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (e_live) begin
        live_cnt <= live_cnt + 1'b1;
      end
    end
  end

  // Write-back decision
  always_comb begin
    do_write = 1'b0;
    old_live = 1'b0;
    no_slot  = 1'b0;
    tgt      = match_idx;
    case (cmd_q)
      tet_pkg::CMD_GENERATE: begin
        if (match_found) begin
          do_write = 1'b1;
          old_live = match_live;
        end else if (free_found) begin
          do_write = 1'b1;
          tgt      = free_idx;
        end else begin
          no_slot = 1'b1;
        end
      end
      tet_pkg::CMD_RENEW: begin
        if (match_found && match_live) begin
          do_write = 1'b1;
          old_live = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // now + lifetime never wraps in 33 bits; live again iff lifetime is nonzero
  assign new_exp     = {1'b0, now_q} + {1'b0, lifetime};
  assign new_live    = do_write && (lifetime != '0);
  assign count_after = live_cnt - tet_pkg::CNT_W'(old_live) + tet_pkg::CNT_W'(new_live);
  assign count_wide  = tet_pkg::SAT_W'(count_after);
  assign count_sat   = (count_wide > tet_pkg::SAT_W'(tet_pkg::COUNT_MAX)) ?
                       tet_pkg::COUNT_W'(tet_pkg::COUNT_MAX) :
                       count_wide[tet_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tet_pkg::TABLE_DEPTH; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (cmd.commit && do_write) begin
      slot_valid[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      mem_key[tgt] <= key_q;
      mem_exp[tgt] <= new_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      live_count <= count_sat;
      applied    <= do_write;
      table_full <= no_slot;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(applied && table_full))
    else $error("applied and table_full both set");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rd_en)
    else $error("commit while a table read is still in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (live_cnt <= tet_pkg::CNT_W'(tet_pkg::TABLE_DEPTH)))
    else $error("live count exceeds table depth");

endmodule

/* rtl/core/token_expiry_table_unit.sv */
// Lease table with expiry. Pulse start while busy is low to issue one transaction
// (command, lease_key, current_time are sampled at that edge). Each transaction
// walks all TABLE_DEPTH slots through a single read port, one slot per cycle,
// then drains the last read and writes back; busy stays high from the first
// scan through write-back, and done pulses for exactly one cycle right after
// busy drops, with live_count, applied and table_full valid only in that
// cycle. There is no backpressure on the result side: the receiver must
// capture the result when done is high. A new start may be issued in the
// same cycle that done is shown. The lifetime register is written through
// cfg_we/cfg_data and should only be changed while busy is low.
module token_expiry_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic [tet_pkg::CMD_W-1:0]    command,
  input  logic [tet_pkg::KEY_W-1:0]    lease_key,
  input  logic [tet_pkg::TIME_W-1:0]   current_time,
  // lifetime register
  input  logic                         cfg_we,
  input  logic [tet_pkg::TIME_W-1:0]   cfg_data,
  // result side, one-cycle strobe
  output logic                         done,
  output logic [tet_pkg::COUNT_W-1:0]  live_count,
  output logic                         applied,
  output logic                         table_full
);

  // controller <-> datapath
  tet_pkg::ctl_cmd_t    ctl_cmd;
  tet_pkg::ctl_status_t ctl_status;

  // Sequencer: idle -> scan every slot -> drain last read -> write back
  tet_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (ctl_status),
    .cmd    (ctl_cmd)
  );

  // Table memory, scan trackers, write-back and result registers
  tet_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl_cmd),
    .status       (ctl_status),
    .command      (command),
    .lease_key    (lease_key),
    .current_time (current_time),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .live_count   (live_count),
    .applied      (applied),
    .table_full   (table_full)
  );

endmodule

/* verif/lease_check_pkg.sv */
package lease_check_pkg;
  import tet_pkg::*;

  // Spare command code, behaves as count only
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] live;
    logic               applied;
    logic               full;
  } lease_answer_t;

  class lease_scoreboard;
    bit                slot_used     [TABLE_DEPTH];
    logic [KEY_W-1:0]  slot_id       [TABLE_DEPTH];
    logic [EXP_W-1:0]  slot_deadline [TABLE_DEPTH];
    logic [TIME_W-1:0] lifetime;
    lease_answer_t     answers[$];
    int unsigned       errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      lifetime = LIFETIME_RESET;
      errors   = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function bit slot_live(int i, logic [TIME_W-1:0] now);
      return slot_used[i] && (slot_deadline[i] > EXP_W'(now));
    endfunction

    // Apply one accepted transaction to the shadow table, queue its answer
    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [TIME_W-1:0] now);
      logic [EXP_W-1:0] deadline;
      lease_answer_t    ans;
      int               hit;
      int               live;
      deadline = EXP_W'(now) + EXP_W'(lifetime);
      ans      = '0;
      hit      = -1;
      live     = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (hit < 0 && slot_used[i] && slot_id[i] == key) hit = i;
      if (cmd == CMD_GENERATE) begin
        // key not held: lowest free or expired slot
        if (hit < 0)
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && !slot_live(i, now)) hit = i;
        if (hit >= 0) begin
          slot_used[hit]     = 1'b1;
          slot_id[hit]       = key;
          slot_deadline[hit] = deadline;
          ans.applied        = 1'b1;
        end else begin
          ans.full = 1'b1;
        end
      end else if (cmd == CMD_RENEW) begin
        if (hit >= 0 && slot_deadline[hit] > EXP_W'(now)) begin
          slot_deadline[hit] = deadline;
          ans.applied        = 1'b1;
        end
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (slot_live(i, now) && live < COUNT_MAX) live++;
      ans.live = COUNT_W'(live);
      answers.push_back(ans);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_answer(logic [COUNT_W-1:0] live, logic app, logic full);
      lease_answer_t want;
      if (answers.size() == 0) begin
        report($sformatf("result with nothing pending (live_count=%0d)", live));
        return;
      end
      want = answers.pop_front();
      if (live !== want.live)
        report($sformatf("live_count got %0d want %0d", live, want.live));
      if (app !== want.applied)
        report($sformatf("applied got %b want %b", app, want.applied));
      if (full !== want.full)
        report($sformatf("table_full got %b want %b", full, want.full));
    endtask
  endclass

endpackage

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tet_pkg::*;
  import lease_check_pkg::*;

  localparam int POOL_SIZE = 40;  // more keys than slots, so the table can fill

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   command = CMD_COUNT;
  logic [KEY_W-1:0]   lease_key = '0;
  logic [TIME_W-1:0]  current_time = '0;
  logic               cfg_we = 1'b0;
  logic [TIME_W-1:0]  cfg_data = '0;
  logic               done;
  logic [COUNT_W-1:0] live_count;
  logic               applied;
  logic               table_full;

  lease_scoreboard book = new();

  token_expiry_table_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .lease_key    (lease_key),
    .current_time (current_time),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .live_count   (live_count),
    .applied      (applied),
    .table_full   (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: the block cannot be held off, so every done cycle is a
  // result. Sampled at the edge itself, so it sees the values from before that edge's updates.
  always @(posedge clk) begin
    if (!rst && done) book.check_answer(live_count, applied, table_full);
  end

  // Present one transaction and hold it until the block takes it. start is
  // left high on return so a following transaction can go back-to-back.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [TIME_W-1:0] now);
    start        <= 1'b1;
    command      <= cmd;
    lease_key    <= key;
    current_time <= now;
    do begin
      @(posedge clk);
    end while (busy);
    book.note_command(cmd, key, now);
  endtask

  // Stop issuing and wait until every outstanding result has come back
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Lifetime is only touched with the block idle
  task automatic set_lifetime(input logic [TIME_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    book.lifetime  = value;
  endtask

  // Sender gap: half the time it starts only once the block
  // has gone idle again, otherwise it lands inside the scan
  task automatic idle_burst();
    start <= 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  // One random phase under a fixed lifetime: keys mostly from a small pool so
  // generates, renews and expiries hit the same entries and the table fills.
  // Time mostly creeps forward; now and then it steps back.
  task automatic run_phase(input logic [TIME_W-1:0] life, input int unsigned step_max,
                           input logic [TIME_W-1:0] base, input int count,
                           input bit allow_idle);
    logic [KEY_W-1:0]  pool [POOL_SIZE];
    logic [TIME_W-1:0] now;
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    int unsigned       roll;
    int unsigned       back;
    set_lifetime(life);
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    now = base;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      cmd = CMD_GENERATE;
      else if (roll < 75) cmd = CMD_RENEW;
      else if (roll < 92) cmd = CMD_COUNT;
      else                cmd = CMD_SPARE;
      if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      else                           key = pool[$urandom_range(0, POOL_SIZE - 1)];
      back = 3 * step_max;
      if ($urandom_range(0, 32) == 0 && now > back)
        now = now - TIME_W'($urandom_range(1, back));
      else
        now = now + TIME_W'($urandom_range(0, step_max));
      issue(cmd, key, now);
      // At most one kind of pause per item: start is dropped at most once per step
      roll = $urandom_range(0, 99);
      if (allow_idle && roll < 2)
        drain_results();
      else if (allow_idle && (k / 40) % 3 != 2 && roll < 30)
        idle_burst();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset lifetime of 1, key extremes, every command code
    issue(CMD_COUNT,    '0, '0);
    issue(CMD_RENEW,    '0, '0);          // renew of an absent key
    issue(CMD_GENERATE, '0, '0);
    issue(CMD_GENERATE, '1, '0);
    issue(CMD_SPARE,    '1, '0);          // spare code counts only
    issue(CMD_RENEW,    '0, '0);
    issue(CMD_COUNT,    '0, 32'd1);       // both leases expire at the boundary
    issue(CMD_RENEW,    '1, 32'd1);       // expired: no renew
    issue(CMD_GENERATE, '1, 32'd1);       // expired key overwritten in place

    // Zero lifetime: lease is dead on arrival and cannot be renewed
    set_lifetime('0);
    issue(CMD_GENERATE, 64'd5, 32'd2);
    issue(CMD_RENEW,    64'd5, 32'd2);
    issue(CMD_COUNT,    64'd5, 32'd2);

    // Largest lifetime at the largest time: expiry needs the 33rd bit
    set_lifetime('1);
    issue(CMD_GENERATE, 64'hA5A5_5A5A_F0F0_0F0F, '1);
    issue(CMD_RENEW,    64'hA5A5_5A5A_F0F0_0F0F, '1);
    issue(CMD_GENERATE, 64'h5A5A_A5A5_0F0F_F0F0, '1);
    issue(CMD_COUNT,    '0, '0);          // time steps backwards
    issue(CMD_RENEW,    64'd5, '0);

    // Random phases; the last one runs without sender gaps
    run_phase(32'd1,         1,   $urandom_range(0, 32'hF000_0000), 135, 1'b1);
    run_phase(32'd0,         2,   $urandom_range(0, 32'hF000_0000), 135, 1'b1);
    run_phase(32'd20,        2,   $urandom_range(0, 32'hF000_0000), 135, 1'b1);
    run_phase(32'd200,       3,   $urandom_range(0, 32'hF000_0000), 135, 1'b1);
    run_phase(32'hFFFF_FFFF, 500, 32'hFFFE_0000 | $urandom_range(0, 32'hFFFF),
              135, 1'b1);
    run_phase($urandom_range(2, 300), 4, $urandom_range(0, 32'hF000_0000), 135, 1'b1);
    run_phase(32'd64,        1,   $urandom_range(0, 32'hF000_0000), 135, 1'b0);

    drain_results();
    // Quiet period to catch any stray done pulse
    repeat (3 * (TABLE_DEPTH + 2)) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
